FILE: design/vdcs_pkg.sv
`default_nettype none
package vdcs_pkg;

  localparam int NUM_PARTICLES = 16;
  localparam int IDX_W = $clog2(NUM_PARTICLES);
  localparam logic [16:0] ONE_Q16 = 17'd65536;

  localparam logic [2:0] ACT_SET  = 3'd0;
  localparam logic [2:0] ACT_COPY = 3'd1;
  localparam logic [2:0] ACT_PRE  = 3'd2;
  localparam logic [2:0] ACT_STICK = 3'd3;
  localparam logic [2:0] ACT_POST = 3'd4;

  typedef struct packed {
    logic [2:0]         action;
    logic [3:0]         first_index;
    logic [3:0]         second_index;
    logic signed [31:0] set_pos_x;
    logic signed [31:0] set_pos_y;
    logic signed [31:0] set_vel_x;
    logic signed [31:0] set_vel_y;
    logic [16:0]        set_drag;
    logic [16:0]        stick_weight;
    logic [30:0]        stick_min_len;
    logic [30:0]        stick_max_len;
  } in_t;

  typedef struct packed {
    logic [3:0]         particle_index;
    logic signed [31:0] out_pos_x;
    logic signed [31:0] out_pos_y;
    logic signed [31:0] out_vel_x;
    logic signed [31:0] out_vel_y;
    logic signed [31:0] out_solver_x;
    logic signed [31:0] out_solver_y;
    logic               last;
  } out_t;

  typedef struct packed {
    logic [16:0]        drag;
    logic signed [31:0] sol_y;
    logic signed [31:0] sol_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_x;
  } rec_t;

endpackage
`default_nettype wire

FILE: design/verlet_distance_constraint_solver.sv
`default_nettype none
// Particle table with Verlet integration and a stick (distance) constraint solver.
// Start an action with start while busy is low; the result words come back on
// result, each marked by result_strobe for a single cycle and never held, so the
// receiver must take them as they come. Stick solve skips the divider when the two
// ends coincide or the stick is already within range, and returns two words,
// first end then second end, in consecutive cycles; its time is set by the 32-step
// square root and the 18-step restoring divider for the normal. The particle records
// live in one memory with a registered read, so the two ends are read one after the
// other. Gravity is written through the cfg channel, which is always ready.
module verlet_distance_constraint_solver (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  vdcs_pkg::in_t   item,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [31:0]     cfg_data,
  output logic            result_strobe,
  output vdcs_pkg::out_t  result
);
  import vdcs_pkg::*;

  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_RDA  = 5'd1;
  localparam logic [4:0] ST_RDB  = 5'd2;
  localparam logic [4:0] ST_DISP = 5'd3;
  localparam logic [4:0] ST_PMUL = 5'd4;
  localparam logic [4:0] ST_PWR  = 5'd5;
  localparam logic [4:0] ST_SQ   = 5'd6;
  localparam logic [4:0] ST_SQI  = 5'd7;
  localparam logic [4:0] ST_SQRT = 5'd8;
  localparam logic [4:0] ST_CMP  = 5'd9;
  localparam logic [4:0] ST_DIV  = 5'd10;
  localparam logic [4:0] ST_NFIN = 5'd11;
  localparam logic [4:0] ST_TMUL = 5'd12;
  localparam logic [4:0] ST_WMUL = 5'd13;
  localparam logic [4:0] ST_WRA  = 5'd14;
  localparam logic [4:0] ST_WRB  = 5'd15;
  localparam logic [4:0] ST_OUTB = 5'd16;

  localparam logic [4:0] DIV_LAST = 5'd17;

  logic [4:0]         state;
  in_t                item_r;
  rec_t               mem [NUM_PARTICLES];
  rec_t               rdata, rec_a, rec_b, wrec;
  logic               we;
  logic [IDX_W-1:0]   raddr, waddr, idx_a, idx_b;
  logic signed [31:0] gravity;
  logic signed [31:0] vx_r, vy_r;
  logic signed [31:0] dx_r, dy_r;
  logic [63:0]        px_r, py_r, sv, sr, sb;
  logic signed [32:0] diff_r;
  logic [50:0]        remx, remy;
  logic [49:0]        dsh;
  logic               negx, negy;
  logic [17:0]        qx, qy;
  logic [4:0]         div_cnt;
  logic signed [18:0] nx_r, ny_r;
  logic signed [34:0] tx_r, ty_r;
  logic [31:0]        cax, cay, cbx, cby;

  logic [31:0]        len, mn, mx, target;
  logic signed [50:0] num_x, num_y;
  logic signed [49:0] pvx, pvy;
  logic signed [49:0] rvx, rvy;
  logic [16:0]        drag_sat, w0;
  logic signed [18:0] w0s, w1s;
  logic signed [51:0] ptx, pty;
  logic signed [53:0] pax, pay, pbx, pby;
  logic               same;
  logic signed [31:0] base_bx, base_by;
  logic [63:0]        sq_try;

  function automatic out_t to_out(logic [3:0] idx, rec_t r, logic lst);
    out_t o;
    o.particle_index = idx;
    o.out_pos_x      = r.pos_x;
    o.out_pos_y      = r.pos_y;
    o.out_vel_x      = r.vel_x;
    o.out_vel_y      = r.vel_y;
    o.out_solver_x   = r.sol_x;
    o.out_solver_y   = r.sol_y;
    o.last           = lst;
    return o;
  endfunction

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign idx_a     = item_r.first_index[IDX_W-1:0];
  assign idx_b     = item_r.second_index[IDX_W-1:0];
  assign raddr     = (state == ST_IDLE) ? item.first_index[IDX_W-1:0] : idx_b;
  assign same      = (idx_a == idx_b);

  // Saturated drag for the write path and saturated stick weights for the sequencer.
  assign drag_sat = (item_r.set_drag > ONE_Q16) ? ONE_Q16 : item_r.set_drag;
  assign w0       = (item_r.stick_weight > ONE_Q16) ? ONE_Q16 : item_r.stick_weight;
  assign w0s      = $signed({2'b00, w0});
  assign w1s      = $signed({2'b00, ONE_Q16}) - w0s;

  assign pvx = rec_a.vel_x * $signed({1'b0, rec_a.drag});
  assign pvy = rec_a.vel_y * $signed({1'b0, rec_a.drag});
  assign rvx = pvx + 50'sd32768;
  assign rvy = pvy + 50'sd32768;

  assign len    = sr[31:0];
  assign mn     = {1'b0, item_r.stick_min_len};
  assign mx     = {1'b0, item_r.stick_max_len};
  always_comb begin
    target = (len < mx) ? len : mx;
    if (target < mn) begin
      target = mn;
    end
  end
  assign num_x = $signed({{2{dx_r[31]}}, dx_r, 17'b0}) + $signed({19'b0, len});
  assign num_y = $signed({{2{dy_r[31]}}, dy_r, 17'b0}) + $signed({19'b0, len});
  assign sq_try = sr + sb;

  assign ptx = diff_r * nx_r;
  assign pty = diff_r * ny_r;
  assign pax = tx_r * w0s;
  assign pay = ty_r * w0s;
  assign pbx = tx_r * w1s;
  assign pby = ty_r * w1s;

  // After the first end is written, rec_a already holds its new solver position.
  assign base_bx = same ? rec_a.sol_x : rec_b.sol_x;
  assign base_by = same ? rec_a.sol_y : rec_b.sol_y;

  always_comb begin
    we    = 1'b0;
    waddr = idx_a;
    wrec  = rec_a;
    unique case (state)
      ST_DISP: begin
        unique case (item_r.action)
          ACT_SET: begin
            we         = 1'b1;
            wrec.pos_x = item_r.set_pos_x;
            wrec.pos_y = item_r.set_pos_y;
            wrec.vel_x = item_r.set_vel_x;
            wrec.vel_y = item_r.set_vel_y;
            wrec.drag  = drag_sat;
          end
          ACT_COPY: begin
            we         = 1'b1;
            wrec.pos_x = rec_b.pos_x;
            wrec.pos_y = rec_b.pos_y;
            wrec.vel_x = rec_b.vel_x;
            wrec.vel_y = rec_b.vel_y;
          end
          ACT_POST: begin
            we         = 1'b1;
            wrec.vel_x = rec_a.sol_x - rec_a.pos_x;
            wrec.vel_y = rec_a.sol_y - rec_a.pos_y;
            wrec.pos_x = rec_a.sol_x;
            wrec.pos_y = rec_a.sol_y;
          end
          default: begin
            we = 1'b0;
          end
        endcase
      end
      ST_PWR: begin
        we         = 1'b1;
        wrec.vel_x = vx_r;
        wrec.vel_y = vy_r + gravity;
        wrec.sol_x = rec_a.pos_x + vx_r;
        wrec.sol_y = rec_a.pos_y + wrec.vel_y;
      end
      ST_WRA: begin
        we         = 1'b1;
        wrec.sol_x = rec_a.sol_x + $signed(cax);
        wrec.sol_y = rec_a.sol_y + $signed(cay);
      end
      ST_WRB: begin
        we         = 1'b1;
        waddr      = idx_b;
        wrec       = rec_b;
        wrec.sol_x = base_bx - $signed(cbx);
        wrec.sol_y = base_by - $signed(cby);
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
    if (we) begin
      mem[waddr] <= wrec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gravity <= '0;
    end else if (cfg_valid && cfg_ready) begin
      gravity <= $signed(cfg_data);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      result_strobe <= 1'b0;
      div_cnt       <= '0;
    end else begin
      result_strobe <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            item_r <= item;
            state  <= ST_RDA;
          end
        end
        ST_RDA: begin
          rec_a <= rdata;
          state <= ST_RDB;
        end
        ST_RDB: begin
          rec_b <= rdata;
          state <= ST_DISP;
        end
        ST_DISP: begin
          unique case (item_r.action)
            ACT_SET, ACT_COPY, ACT_POST: begin
              result        <= to_out(item_r.first_index, wrec, 1'b1);
              result_strobe <= 1'b1;
              state         <= ST_IDLE;
            end
            ACT_PRE: begin
              state <= ST_PMUL;
            end
            ACT_STICK: begin
              dx_r  <= rec_b.sol_x - rec_a.sol_x;
              dy_r  <= rec_b.sol_y - rec_a.sol_y;
              state <= ST_SQ;
            end
            default: begin
              state <= ST_IDLE;
            end
          endcase
        end
        ST_PMUL: begin
          vx_r  <= rvx[47:16];
          vy_r  <= rvy[47:16];
          state <= ST_PWR;
        end
        ST_PWR: begin
          result        <= to_out(item_r.first_index, wrec, 1'b1);
          result_strobe <= 1'b1;
          state         <= ST_IDLE;
        end
        ST_SQ: begin
          px_r  <= dx_r * dx_r;
          py_r  <= dy_r * dy_r;
          state <= ST_SQI;
        end
        ST_SQI: begin
          sv    <= px_r + py_r;
          sr    <= '0;
          sb    <= 64'h4000_0000_0000_0000;
          state <= ST_SQRT;
        end
        ST_SQRT: begin
          if (sv >= sq_try) begin
            sv <= sv - sq_try;
            sr <= (sr >> 1) + sb;
          end else begin
            sr <= sr >> 1;
          end
          sb <= sb >> 2;
          if (sb[0]) begin
            state <= ST_CMP;
          end
        end
        ST_CMP: begin
          diff_r <= $signed({1'b0, len}) - $signed({1'b0, target});
          if (mn <= len && len <= mx) begin
            tx_r  <= '0;
            ty_r  <= '0;
            state <= ST_WMUL;
          end else if (len == '0) begin
            nx_r  <= $signed({2'b00, ONE_Q16});
            ny_r  <= '0;
            state <= ST_TMUL;
          end else begin
            negx    <= num_x[50];
            negy    <= num_y[50];
            remx    <= num_x[50] ? 51'(-num_x) : 51'(num_x);
            remy    <= num_y[50] ? 51'(-num_y) : 51'(num_y);
            dsh     <= {len, 18'b0};
            div_cnt <= '0;
            state   <= ST_DIV;
          end
        end
        ST_DIV: begin
          // Restoring division: one quotient bit per lane per cycle, most significant first.
          if (remx >= {1'b0, dsh}) begin
            remx <= remx - {1'b0, dsh};
          end
          if (remy >= {1'b0, dsh}) begin
            remy <= remy - {1'b0, dsh};
          end
          qx      <= {qx[16:0], (remx >= {1'b0, dsh})};
          qy      <= {qy[16:0], (remy >= {1'b0, dsh})};
          dsh     <= dsh >> 1;
          div_cnt <= div_cnt + 5'd1;
          if (div_cnt == DIV_LAST) begin
            state <= ST_NFIN;
          end
        end
        ST_NFIN: begin
          // Floor of a negative quotient steps down when there is a remainder.
          nx_r  <= negx ? (-$signed({1'b0, qx}) - $signed({18'b0, (remx != '0)}))
                        : $signed({1'b0, qx});
          ny_r  <= negy ? (-$signed({1'b0, qy}) - $signed({18'b0, (remy != '0)}))
                        : $signed({1'b0, qy});
          state <= ST_TMUL;
        end
        ST_TMUL: begin
          tx_r  <= 35'((ptx + 52'sd32768) >>> 16);
          ty_r  <= 35'((pty + 52'sd32768) >>> 16);
          state <= ST_WMUL;
        end
        ST_WMUL: begin
          cax   <= 32'((pax + 54'sd32768) >>> 16);
          cay   <= 32'((pay + 54'sd32768) >>> 16);
          cbx   <= 32'((pbx + 54'sd32768) >>> 16);
          cby   <= 32'((pby + 54'sd32768) >>> 16);
          state <= ST_WRA;
        end
        ST_WRA: begin
          rec_a.sol_x <= wrec.sol_x;
          rec_a.sol_y <= wrec.sol_y;
          state       <= ST_WRB;
        end
        ST_WRB: begin
          rec_b.sol_x <= wrec.sol_x;
          rec_b.sol_y <= wrec.sol_y;
          if (same) begin
            result <= to_out(item_r.first_index, wrec, 1'b0);
          end else begin
            result <= to_out(item_r.first_index, rec_a, 1'b0);
          end
          result_strobe <= 1'b1;
          state         <= ST_OUTB;
        end
        ST_OUTB: begin
          result        <= to_out(item_r.second_index, rec_b, 1'b1);
          result_strobe <= 1'b1;
          state         <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    we |-> state != ST_IDLE) else $error("memory written while idle");
  a_first_end_pair: assert property (@(posedge clk) disable iff (rst)
    result_strobe && !result.last |=> result_strobe && result.last)
    else $error("first stick word not followed by the second");
  a_div_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> div_cnt <= DIV_LAST) else $error("divider overran");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && busy |=> $stable(item_r)) else $error("item latched while busy");
`endif

endmodule
`default_nettype wire

FILE: verif/tb_verlet_distance_constraint_solver.sv
`default_nettype none
module tb_verlet_distance_constraint_solver;
  timeunit 1ns;
  timeprecision 1ps;
  import vdcs_pkg::*;

  localparam int  LIMIT   = 1000000;
  localparam int  SETTLE  = 100;
  localparam int  PHASE_N = 300;

  logic   clk;
  logic   rst;
  logic   start;
  logic   busy;
  in_t    item;
  logic   cfg_valid;
  logic   cfg_ready;
  logic   [31:0] cfg_data;
  logic   result_strobe;
  out_t   result;

  int     errors;
  int     cycles;
  bit     idling;

  verlet_distance_constraint_solver DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .result_strobe(result_strobe), .result(result)
  );

  task automatic mismatch(string what);
    $display("MISMATCH at cycle %0d: %s", cycles, what);
    errors++;
  endtask

  typedef struct {
    out_t word;
    bit   sol_known;
  } report_t;

  // Keeps its own particle table and predicts every word the block reports.
  class particle_table;
    logic [31:0] pos_x[16], pos_y[16], vel_x[16], vel_y[16], sol_x[16], sol_y[16];
    logic [16:0] drag[16];
    bit          pv_ok[16], drag_ok[16], sol_ok[16];
    logic [31:0] gravity;
    report_t     reports[$];

    function longint sx(logic [31:0] v);
      return longint'(signed'(v));
    endfunction

    function longint fdiv(longint n, longint d);
      longint q;
      q = n / d;
      if ((n % d) != 0 && n < 0) q--;
      return q;
    endfunction

    function longint rnd16(longint p);
      return fdiv(p + 32768, 65536);
    endfunction

    function longint unsigned isqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function longint sat(logic [16:0] v);
      return (v > ONE_Q16) ? 65536 : longint'(v);
    endfunction

    function void push(int i, bit lst);
      report_t r;
      r.word.particle_index = 4'(i);
      r.word.out_pos_x = pos_x[i];
      r.word.out_pos_y = pos_y[i];
      r.word.out_vel_x = vel_x[i];
      r.word.out_vel_y = vel_y[i];
      r.word.out_solver_x = sol_x[i];
      r.word.out_solver_y = sol_y[i];
      r.word.last = lst;
      r.sol_known = sol_ok[i];
      reports.push_back(r);
    endfunction

    function void stick(int a, int b, longint w0, longint mn, longint mx);
      longint dx, dy, len, target, diff, nx, ny, tx, ty, w1;
      longint unsigned sq;
      dx = sx(sol_x[b] - sol_x[a]);
      dy = sx(sol_y[b] - sol_y[a]);
      sq = longint'(dx * dx) + longint'(dy * dy);
      len = longint'(isqrt(sq));
      w1 = 65536 - w0;
      if (mn <= len && len <= mx) return;
      target = (len < mx) ? len : mx;
      if (target < mn) target = mn;
      diff = len - target;
      nx = 65536;
      ny = 0;
      if (len != 0) begin
        nx = fdiv(2 * (dx * 65536) + len, 2 * len);
        ny = fdiv(2 * (dy * 65536) + len, 2 * len);
      end
      tx = rnd16(diff * nx);
      ty = rnd16(diff * ny);
      sol_x[a] = 32'(sx(sol_x[a]) + rnd16(tx * w0));
      sol_y[a] = 32'(sx(sol_y[a]) + rnd16(ty * w0));
      sol_x[b] = 32'(sx(sol_x[b]) - rnd16(tx * w1));
      sol_y[b] = 32'(sx(sol_y[b]) - rnd16(ty * w1));
    endfunction

    function void note(in_t it);
      int a, b;
      longint vx, vy, d;
      a = int'(it.first_index);
      b = int'(it.second_index);
      case (it.action)
        ACT_SET: begin
          pos_x[a] = it.set_pos_x;
          pos_y[a] = it.set_pos_y;
          vel_x[a] = it.set_vel_x;
          vel_y[a] = it.set_vel_y;
          drag[a] = 17'(sat(it.set_drag));
          pv_ok[a] = 1;
          drag_ok[a] = 1;
          push(a, 1);
        end
        ACT_COPY: begin
          pos_x[a] = pos_x[b];
          pos_y[a] = pos_y[b];
          vel_x[a] = vel_x[b];
          vel_y[a] = vel_y[b];
          pv_ok[a] = 1;
          push(a, 1);
        end
        ACT_PRE: begin
          d = longint'(drag[a]);
          vx = rnd16(sx(vel_x[a]) * d);
          vy = rnd16(sx(vel_y[a]) * d);
          vy = sx(vy[31:0]) + sx(gravity);
          vel_x[a] = vx[31:0];
          vel_y[a] = vy[31:0];
          sol_x[a] = 32'(sx(pos_x[a]) + sx(vx[31:0]));
          sol_y[a] = 32'(sx(pos_y[a]) + sx(vy[31:0]));
          sol_ok[a] = 1;
          push(a, 1);
        end
        ACT_STICK: begin
          stick(a, b, sat(it.stick_weight), longint'(it.stick_min_len),
                longint'(it.stick_max_len));
          push(a, 0);
          push(b, 1);
        end
        ACT_POST: begin
          vel_x[a] = sol_x[a] - pos_x[a];
          vel_y[a] = sol_y[a] - pos_y[a];
          pos_x[a] = sol_x[a];
          pos_y[a] = sol_y[a];
          push(a, 1);
        end
        default: ;
      endcase
    endfunction

    task cmp(string f, logic [31:0] got, logic [31:0] want);
      if (got !== want)
        mismatch($sformatf("%s got %h expected %h", f, got, want));
    endtask

    task check(out_t w);
      report_t r;
      if (reports.size() == 0) begin
        mismatch("result word with nothing expected");
        return;
      end
      r = reports.pop_front();
      cmp("particle_index", 32'(w.particle_index), 32'(r.word.particle_index));
      cmp("out_pos_x", w.out_pos_x, r.word.out_pos_x);
      cmp("out_pos_y", w.out_pos_y, r.word.out_pos_y);
      cmp("out_vel_x", w.out_vel_x, r.word.out_vel_x);
      cmp("out_vel_y", w.out_vel_y, r.word.out_vel_y);
      // A particle that was never pre-integrated has no defined solver position.
      if (r.sol_known) begin
        cmp("out_solver_x", w.out_solver_x, r.word.out_solver_x);
        cmp("out_solver_y", w.out_solver_y, r.word.out_solver_y);
      end
      cmp("last", 32'(w.last), 32'(r.word.last));
    endtask
  endclass

  particle_table table_model;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && result_strobe) table_model.check(result);
  end

  function automatic logic [31:0] near_value();
    return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
  endfunction

  function automatic logic [31:0] any_value();
    return ($urandom_range(0, 3) == 0) ? $urandom() : near_value();
  endfunction

  function automatic in_t make_item(logic [2:0] act, int a, int b);
    in_t it;
    it.action = act;
    it.first_index = 4'(a);
    it.second_index = 4'(b);
    it.set_pos_x = any_value();
    it.set_pos_y = any_value();
    it.set_vel_x = any_value();
    it.set_vel_y = any_value();
    it.set_drag = ($urandom_range(0, 7) == 0) ? 17'($urandom())
                                              : 17'($urandom_range(55000, 65536));
    it.stick_weight = ($urandom_range(0, 7) == 0) ? 17'($urandom())
                                                  : 17'($urandom_range(0, 65536));
    if ($urandom_range(0, 5) == 0) begin
      it.stick_min_len = 31'($urandom());
      it.stick_max_len = 31'($urandom());
    end else begin
      it.stick_min_len = 31'($urandom_range(0, 32'h0004_0000));
      it.stick_max_len = 31'(it.stick_min_len + $urandom_range(0, 32'h0002_0000));
    end
    return it;
  endfunction

  // Well-formed most of the time: an action whose inputs were never defined
  // is turned into a set of its first particle.
  function automatic in_t random_item();
    int a, b, pick;
    logic [2:0] act;
    a = $urandom_range(0, 15);
    b = $urandom_range(0, 15);
    pick = $urandom_range(0, 99);
    if (pick < 15) act = ACT_SET;
    else if (pick < 25) act = ACT_COPY;
    else if (pick < 50) act = ACT_PRE;
    else if (pick < 80) act = ACT_STICK;
    else if (pick < 95) act = ACT_POST;
    else act = 3'($urandom_range(5, 7));
    case (act)
      ACT_COPY:  if (!table_model.pv_ok[b]) act = ACT_SET;
      ACT_PRE:   if (!table_model.pv_ok[a] || !table_model.drag_ok[a]) act = ACT_SET;
      ACT_STICK: if (!table_model.sol_ok[a] || !table_model.sol_ok[b]) act = ACT_SET;
      ACT_POST:  if (!table_model.pv_ok[a] || !table_model.sol_ok[a]) act = ACT_SET;
      default: ;
    endcase
    return make_item(act, a, b);
  endfunction

  task automatic send(in_t it);
    int gap;
    item <= it;
    start <= 1;
    @(posedge clk);
    while (busy) @(posedge clk);
    table_model.note(it);
    if (idling && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 14);
      start <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    start <= 0;
    @(posedge clk);
    while (table_model.reports.size() != 0 || busy) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_gravity(logic [31:0] g);
    wait_idle();
    cfg_data <= g;
    cfg_valid <= 1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    table_model.gravity = g;
  endtask

  task automatic directed();
    in_t it;
    it = make_item(ACT_SET, 0, 0);
    it.set_pos_x = 32'h7FFF_FFFF; it.set_pos_y = 32'h7FFF_FFFF;
    it.set_vel_x = 32'h7FFF_FFFF; it.set_vel_y = 32'h7FFF_FFFF;
    it.set_drag = ONE_Q16;
    send(it);
    it = make_item(ACT_SET, 1, 0);
    it.set_pos_x = 32'h8000_0000; it.set_pos_y = 32'h8000_0000;
    it.set_vel_x = 32'h8000_0000; it.set_vel_y = 32'h8000_0000;
    it.set_drag = 17'h1FFFF;
    send(it);
    it = make_item(ACT_SET, 2, 0);
    it.set_pos_x = '0; it.set_pos_y = '0; it.set_vel_x = '0; it.set_vel_y = '0;
    it.set_drag = '0;
    send(it);
    send(make_item(ACT_SET, 3, 0));
    it = make_item(ACT_SET, 5, 0);
    send(it);
    it.first_index = 4'd6;
    send(it);
    for (int i = 0; i < 7; i++) if (i != 4) send(make_item(ACT_PRE, i, 0));
    send(make_item(ACT_COPY, 4, 1));
    it = make_item(ACT_STICK, 0, 1);
    it.stick_weight = 17'h1FFFF;
    send(it);
    // The two ends coincide, so the normal falls back to the x axis.
    it = make_item(ACT_STICK, 5, 6);
    it.stick_min_len = 31'h0001_0000; it.stick_max_len = 31'h0002_0000;
    it.stick_weight = '0;
    send(it);
    it = make_item(ACT_STICK, 3, 3);
    send(it);
    // Maximum below minimum.
    it = make_item(ACT_STICK, 2, 3);
    it.stick_min_len = 31'h7FFF_FFFF; it.stick_max_len = 31'h0000_1000;
    send(it);
    it = make_item(ACT_STICK, 3, 2);
    it.stick_min_len = '0; it.stick_max_len = '0;
    send(it);
    send(make_item(ACT_POST, 0, 0));
    send(make_item(ACT_POST, 3, 0));
    for (int a = 5; a < 8; a++) send(make_item(3'(a), 15, 15));
  endtask

  initial begin
    logic [31:0] grav_list[4];
    table_model = new();
    table_model.gravity = 0;
    errors = 0;
    cycles = 0;
    idling = 1;
    rst = 1;
    start = 0;
    item = '0;
    cfg_valid = 0;
    cfg_data = '0;
    repeat (9) @(posedge clk);
    rst <= 0;
    write_gravity(near_value());
    directed();
    grav_list[0] = 32'h7FFF_FFFF;
    grav_list[1] = 32'h8000_0000;
    grav_list[2] = $urandom();
    grav_list[3] = 32'hFFFF_F000;
    for (int p = 0; p < 4; p++) begin
      write_gravity(grav_list[p]);
      if (p == 3) idling = 0;
      for (int n = 0; n < PHASE_N; n++) send(random_item());
    end
    start <= 0;
    @(posedge clk);
    while (table_model.reports.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (errors == 0 && table_model.reports.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

FILE: filelist.f
design/vdcs_pkg.sv
design/verlet_distance_constraint_solver.sv
verif/tb_verlet_distance_constraint_solver.sv
